// ===== rtl/core/mses_pkg.sv =====
// Shared types, codes and constants of the shortest edit script engine.
package mses_pkg;

	localparam int MAX_LINES_DEF   = 32;
	localparam int SYMBOL_BITS_DEF = 32;

	localparam int KIND_W   = 2;
	localparam int SYM_IN_W = 32;
	localparam int OP_W     = 2;
	localparam int LINE_W   = 6;
	localparam int STAT_W   = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_OLD   = 2'd0,
		KIND_NEW   = 2'd1,
		KIND_START = 2'd2
	} kind_t;

	// The spare kind code, which the engine swallows without a result.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef enum logic [OP_W-1:0] {
		OP_EQ  = 2'd0,
		OP_INS = 2'd1,
		OP_DEL = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_NORMAL = 2'd0,
		STAT_EMPTY  = 2'd1,
		STAT_OVF    = 2'd2
	} stat_t;

	// One classified command handed from the front to the back.
	typedef struct packed {
		kind_t                kind;
		logic [SYM_IN_W-1:0]  symbol;
	} cmd_t;

endpackage

// ===== rtl/core/mses_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module mses_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/mses_front.sv =====
// Front end: accepts input items, drops unused kinds and queues commands.
module mses_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mses_pkg::KIND_W-1:0]   kind,
	input  logic [mses_pkg::SYM_IN_W-1:0] line_symbol,
	output logic                          q_valid,
	output mses_pkg::cmd_t                q_cmd,
	input  logic                          q_pop
);

	mses_pkg::cmd_t                 entries_q [mses_pkg::QUEUE_DEPTH];
	logic [mses_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [mses_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [mses_pkg::QCNT_W-1:0]    count_q;
	logic                           known;
	logic                           push;
	logic                           pop;

	// Only the three defined kinds become commands; the spare code is swallowed.
	assign known = (kind == mses_pkg::KIND_OLD) || (kind == mses_pkg::KIND_NEW) ||
		(kind == mses_pkg::KIND_START);

	assign in_ready = (count_q != mses_pkg::QCNT_W'(mses_pkg::QUEUE_DEPTH));
	assign push     = in_valid && in_ready && known;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_cmd    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= '{kind: mses_pkg::kind_t'(kind), symbol: line_symbol};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= mses_pkg::QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= mses_pkg::QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/mses_back.sv =====
// Back end: symbol stores, Myers forward search, backtrace and result output.
module mses_back #(
	parameter int MAX_LINES   = mses_pkg::MAX_LINES_DEF,
	parameter int SYMBOL_BITS = mses_pkg::SYMBOL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  mses_pkg::cmd_t              q_cmd,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mses_pkg::OP_W-1:0]   op,
	output logic [mses_pkg::LINE_W-1:0] old_line,
	output logic [mses_pkg::LINE_W-1:0] new_line,
	output logic [mses_pkg::STAT_W-1:0] status,
	output logic                        last
);

	localparam int ML   = MAX_LINES;
	localparam int DMAX = 2 * ML;
	localparam int VW   = 2 * DMAX + 1;
	localparam int HD   = (DMAX + 1) * VW;
	localparam int AW   = $clog2(HD);
	localparam int CW   = $clog2(VW);
	localparam int DW   = $clog2(DMAX + 1);
	localparam int LW   = $clog2(ML + 1);
	localparam int IW   = (ML > 1) ? $clog2(ML) : 1;
	localparam int SW   = $clog2(5 * ML + 1) + 1;
	localparam int CNW  = $clog2(2 * ML + 1);
	localparam int RAW  = $clog2(2 * ML);
	localparam int RW   = mses_pkg::OP_W + 2 * LW;
	localparam int SYW  = (SYMBOL_BITS < mses_pkg::SYM_IN_W) ? SYMBOL_BITS : mses_pkg::SYM_IN_W;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_F_RD1  = 13'b0000000000010,
		ST_F_RD2  = 13'b0000000000100,
		ST_F_RD3  = 13'b0000000001000,
		ST_F_SNK  = 13'b0000000010000,
		ST_F_CMP  = 13'b0000000100000,
		ST_B_TOP  = 13'b0000001000000,
		ST_B_RD2  = 13'b0000010000000,
		ST_B_RD3  = 13'b0000100000000,
		ST_B_SNK  = 13'b0001000000000,
		ST_B_TAIL = 13'b0010000000000,
		ST_E_RD   = 13'b0100000000000,
		ST_E_OUT  = 13'b1000000000000
	} state_t;

	state_t                state_q;
	logic [LW-1:0]         old_len_q;
	logic [LW-1:0]         new_len_q;
	logic                  ovf_q;
	logic signed [SW-1:0]  x_q;
	logic signed [SW-1:0]  y_q;
	logic signed [SW-1:0]  k_q;
	logic signed [SW-1:0]  lo_q;
	logic signed [SW-1:0]  mx_q;
	logic signed [SW-1:0]  my_q;
	logic                  up_q;
	logic                  mismatch_q;
	logic [DW-1:0]         d_q;
	logic [AW-1:0]         row_q;
	logic [CNW-1:0]        cnt_q;
	logic [RAW-1:0]        ri_q;

	logic                           out_valid_q;
	logic [mses_pkg::OP_W-1:0]      op_q;
	logic [mses_pkg::LINE_W-1:0]    old_line_q;
	logic [mses_pkg::LINE_W-1:0]    new_line_q;
	logic [mses_pkg::STAT_W-1:0]    status_q;
	logic                           last_q;

	logic signed [SW-1:0]  n_s;
	logic signed [SW-1:0]  m_s;
	logic signed [SW-1:0]  d_s;
	logic signed [SW-1:0]  kb;
	logic signed [SW-1:0]  kr;
	logic signed [SW-1:0]  k_lo;
	logic signed [SW-1:0]  k_hi;
	logic signed [SW-1:0]  k_rd;
	logic signed [SW-1:0]  hi;
	logic signed [SW-1:0]  px;
	logic signed [SW-1:0]  pk;
	logic signed [SW-1:0]  py;
	logic                  up;
	logic [AW-1:0]         prev_row;
	logic [CW-1:0]         rd_col;
	logic [CW-1:0]         wr_col;

	logic                  can_load;
	logic                  load_out;
	logic                  hist_we;
	logic [AW-1:0]         hist_raddr;
	logic [AW-1:0]         hist_waddr;
	logic [SW-1:0]         hist_rdata;
	logic                  old_we;
	logic                  new_we;
	logic [SYW-1:0]        old_rdata;
	logic [SYW-1:0]        new_rdata;
	logic                  rev_we;
	logic [RW-1:0]         rev_wdata;
	logic [RW-1:0]         rev_rdata;
	logic                  snake_fwd;
	logic                  snake_bwd;
	logic                  tail_eq;
	logic                  cnt_full;

	assign n_s      = SW'(old_len_q);
	assign m_s      = SW'(new_len_q);
	assign d_s      = SW'(d_q);
	assign kb       = x_q - y_q;
	assign kr       = (state_q == ST_B_TOP) ? kb : k_q;
	assign k_lo     = (kr == -d_s) ? kr + SW'(1) : kr - SW'(1);
	assign k_hi     = (kr == d_s) ? kr - SW'(1) : kr + SW'(1);
	assign k_rd     = ((state_q == ST_F_RD1) || (state_q == ST_B_TOP)) ? k_lo : k_hi;
	assign prev_row = row_q - AW'(VW);
	assign rd_col   = CW'(k_rd + SW'(DMAX));
	assign wr_col   = CW'(k_q + SW'(DMAX));
	assign hist_raddr = prev_row + AW'(rd_col);
	assign hist_waddr = row_q + AW'(wr_col);

	// Pick the diagonal that the previous depth reached furthest on.
	assign hi = $signed(hist_rdata);
	assign up = (k_q == -d_s) || ((k_q != d_s) && (lo_q < hi));
	assign px = up ? hi : lo_q;
	assign pk = up ? k_q + SW'(1) : k_q - SW'(1);
	assign py = px - pk;

	// The forward snake also ends once a pair of lines has compared unequal.
	assign cnt_full  = (cnt_q >= CNW'(2 * ML));
	assign snake_fwd = (x_q < n_s) && (y_q < m_s) && !mismatch_q;
	assign snake_bwd = (x_q > mx_q) && (y_q > my_q) && !cnt_full;
	assign tail_eq   = (x_q != '0) && (y_q != '0) && !cnt_full;
	assign can_load  = !out_valid_q || out_ready;

	assign load_out = ((state_q == ST_IDLE) && q_pop && (q_cmd.kind == mses_pkg::KIND_START) &&
		(ovf_q || (old_len_q == '0 && new_len_q == '0))) ||
		((state_q == ST_E_OUT) && can_load);

	assign hist_we = (state_q == ST_F_SNK) && !snake_fwd;
	assign old_we  = (state_q == ST_IDLE) && q_pop && (q_cmd.kind == mses_pkg::KIND_OLD) &&
		(old_len_q < LW'(ML));
	assign new_we  = (state_q == ST_IDLE) && q_pop && (q_cmd.kind == mses_pkg::KIND_NEW) &&
		(new_len_q < LW'(ML));

	always_comb begin
		rev_we    = 1'b0;
		rev_wdata = {mses_pkg::OP_EQ, LW'(x_q), LW'(y_q)};
		case (state_q)
			ST_B_SNK: begin
				rev_we = !cnt_full;
				if (!snake_bwd) begin
					if (up_q) begin
						rev_wdata = {mses_pkg::OP_INS, LW'(0), LW'(y_q)};
					end else begin
						rev_wdata = {mses_pkg::OP_DEL, LW'(x_q), LW'(0)};
					end
				end
			end
			ST_B_TAIL: begin
				rev_we = tail_eq;
			end
			default: begin
				rev_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		if (state_q == ST_IDLE && q_valid) begin
			q_pop = (q_cmd.kind != mses_pkg::KIND_START) || can_load;
		end
	end

	mses_ram #(.WIDTH(SYW), .DEPTH(ML)) u_old_ram (
		.clk   (clk),
		.we    (old_we),
		.waddr (IW'(old_len_q)),
		.wdata (q_cmd.symbol[SYW-1:0]),
		.raddr (IW'(x_q)),
		.rdata (old_rdata)
	);

	mses_ram #(.WIDTH(SYW), .DEPTH(ML)) u_new_ram (
		.clk   (clk),
		.we    (new_we),
		.waddr (IW'(new_len_q)),
		.wdata (q_cmd.symbol[SYW-1:0]),
		.raddr (IW'(y_q)),
		.rdata (new_rdata)
	);

	mses_ram #(.WIDTH(SW), .DEPTH(HD)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (x_q),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	mses_ram #(.WIDTH(RW), .DEPTH(2 * ML)) u_rev_ram (
		.clk   (clk),
		.we    (rev_we),
		.waddr (RAW'(cnt_q)),
		.wdata (rev_wdata),
		.raddr (ri_q),
		.rdata (rev_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			old_len_q   <= '0;
			new_len_q   <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_cmd.kind)
							mses_pkg::KIND_OLD: begin
								if (old_len_q < LW'(ML)) begin
									old_len_q <= old_len_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							mses_pkg::KIND_NEW: begin
								if (new_len_q < LW'(ML)) begin
									new_len_q <= new_len_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							mses_pkg::KIND_START: begin
								if (ovf_q || (old_len_q == '0 && new_len_q == '0)) begin
									old_len_q   <= '0;
									new_len_q   <= '0;
									ovf_q       <= 1'b0;
								end else begin
									state_q <= ST_F_RD1;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_F_RD1: begin
					state_q <= (d_q == '0) ? ST_F_SNK : ST_F_RD2;
				end
				ST_F_RD2: state_q <= ST_F_RD3;
				ST_F_RD3: state_q <= ST_F_SNK;
				ST_F_SNK: begin
					if (snake_fwd) begin
						state_q <= ST_F_CMP;
					end else if ((x_q >= n_s) && (y_q >= m_s)) begin
						state_q <= ST_B_TOP;
					end else begin
						state_q <= ST_F_RD1;
					end
				end
				ST_F_CMP: begin
					state_q <= ST_F_SNK;
				end
				ST_B_TOP: begin
					state_q <= (d_q == '0) ? ST_B_TAIL : ST_B_RD2;
				end
				ST_B_RD2: state_q <= ST_B_RD3;
				ST_B_RD3: state_q <= ST_B_SNK;
				ST_B_SNK: begin
					if (cnt_full) begin
						state_q <= ST_E_RD;
					end else if (!snake_bwd) begin
						state_q <= ST_B_TOP;
					end
				end
				ST_B_TAIL: begin
					if (!tail_eq) begin
						state_q <= ST_E_RD;
					end
				end
				ST_E_RD: state_q <= ST_E_OUT;
				ST_E_OUT: begin
					if (can_load) begin
						if (ri_q == '0) begin
							state_q   <= ST_IDLE;
							old_len_q <= '0;
							new_len_q <= '0;
							ovf_q     <= 1'b0;
						end else begin
							state_q <= ST_E_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the search and of the result register.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				d_q   <= '0;
				k_q   <= '0;
				row_q <= '0;
				cnt_q <= '0;
				if (q_pop && (q_cmd.kind == mses_pkg::KIND_START)) begin
					op_q       <= mses_pkg::OP_EQ;
					old_line_q <= '0;
					new_line_q <= '0;
					status_q   <= ovf_q ? mses_pkg::STAT_OVF : mses_pkg::STAT_EMPTY;
					last_q     <= 1'b1;
				end
			end
			ST_F_RD1: begin
				mismatch_q <= 1'b0;
				if (d_q == '0) begin
					x_q <= '0;
					y_q <= '0;
				end
			end
			ST_F_RD2: begin
				lo_q <= hi;
			end
			ST_F_RD3: begin
				x_q <= up ? hi : lo_q + SW'(1);
				y_q <= (up ? hi : lo_q + SW'(1)) - k_q;
			end
			ST_F_SNK: begin
				if (!snake_fwd) begin
					if ((x_q >= n_s) && (y_q >= m_s)) begin
						x_q <= n_s;
						y_q <= m_s;
					end else if (k_q == d_s) begin
						d_q   <= d_q + 1'b1;
						k_q   <= -(d_s + SW'(1));
						row_q <= row_q + AW'(VW);
					end else begin
						k_q <= k_q + SW'(2);
					end
				end
			end
			ST_F_CMP: begin
				mismatch_q <= (old_rdata != new_rdata);
				if (old_rdata == new_rdata) begin
					x_q <= x_q + SW'(1);
					y_q <= y_q + SW'(1);
				end
			end
			ST_B_TOP: begin
				k_q <= kb;
			end
			ST_B_RD2: begin
				lo_q <= hi;
			end
			ST_B_RD3: begin
				up_q <= up;
				mx_q <= up ? px : px + SW'(1);
				my_q <= up ? py + SW'(1) : py;
			end
			ST_B_SNK: begin
				if (cnt_full) begin
					ri_q <= RAW'(cnt_q - CNW'(1));
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (snake_bwd) begin
						x_q <= x_q - SW'(1);
						y_q <= y_q - SW'(1);
					end else begin
						d_q   <= d_q - 1'b1;
						row_q <= prev_row;
						if (up_q) begin
							y_q <= y_q - SW'(1);
						end else begin
							x_q <= x_q - SW'(1);
						end
					end
				end
			end
			ST_B_TAIL: begin
				if (tail_eq) begin
					cnt_q <= cnt_q + 1'b1;
					x_q   <= x_q - SW'(1);
					y_q   <= y_q - SW'(1);
				end else begin
					ri_q <= RAW'(cnt_q - CNW'(1));
				end
			end
			ST_E_OUT: begin
				if (can_load) begin
					op_q       <= rev_rdata[RW-1 -: mses_pkg::OP_W];
					old_line_q <= mses_pkg::LINE_W'(rev_rdata[2*LW-1:LW]);
					new_line_q <= mses_pkg::LINE_W'(rev_rdata[LW-1:0]);
					status_q   <= mses_pkg::STAT_NORMAL;
					last_q     <= (ri_q == '0);
					if (ri_q != '0) begin
						ri_q <= ri_q - 1'b1;
					end
				end
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign op        = op_q;
	assign old_line  = old_line_q;
	assign new_line  = new_line_q;
	assign status    = status_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != mses_pkg::STAT_NORMAL) |->
		last_q && (old_line_q == '0) && (new_line_q == '0))
		else $error("status item is not a lone final item");

	a_insert_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (op_q == mses_pkg::OP_INS) |-> (old_line_q == '0) && (new_line_q != '0))
		else $error("insert item carries wrong line numbers");

	a_delete_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (op_q == mses_pkg::OP_DEL) |-> (new_line_q == '0) && (old_line_q != '0))
		else $error("delete item carries wrong line numbers");
`endif

endmodule

// ===== rtl/core/myers_shortest_edit_script.sv =====
// Top level of the Myers shortest edit script engine.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | kind, line_symbol
//  output  | out_valid / out_ready| op, old_line, new_line, status, last
//
// A load item is taken by the back end once it reaches the head of the queue
// while the back end is idle. A start item runs the forward search over
// (D+1)(D+2)/2 diagonals, following the snake of matched lines on each (one
// port on the history RAM, registered reads), then backtraces the edit steps
// and equal lines into a reverse store and emits the result items from it in
// script order under the output handshake.
// Reset clears the lengths, the overflow flag, the queue and the output
// valid flag; the symbol and history stores need no clear.
// A stalled output holds the engine; the two-entry queue keeps taking items,
// until it is full, while the back end works or waits.
module myers_shortest_edit_script #(
	parameter int MAX_LINES   = mses_pkg::MAX_LINES_DEF,
	parameter int SYMBOL_BITS = mses_pkg::SYMBOL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mses_pkg::KIND_W-1:0]   kind,
	input  logic [mses_pkg::SYM_IN_W-1:0] line_symbol,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mses_pkg::OP_W-1:0]     op,
	output logic [mses_pkg::LINE_W-1:0]   old_line,
	output logic [mses_pkg::LINE_W-1:0]   new_line,
	output logic [mses_pkg::STAT_W-1:0]   status,
	output logic                          last
);

	// Classified commands waiting for the back end.
	logic           q_valid;
	logic           q_pop;
	mses_pkg::cmd_t q_cmd;

	mses_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.line_symbol (line_symbol),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_pop       (q_pop)
	);

	// The back end owns all stores and produces every result item.
	mses_back #(
		.MAX_LINES   (MAX_LINES),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.op        (op),
		.old_line  (old_line),
		.new_line  (new_line),
		.status    (status),
		.last      (last)
	);

endmodule
